// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the gang lock arbiter.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gang lock arbiter assertion failed");
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gang lock arbiter reset assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== rtl/gla_pkg.sv =====
// Package of the gang lock arbiter: field widths, codes and defaults.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package gla_pkg;

  localparam int GLA_NUM_CORES = 8;

  localparam int OpW       = 2;
  localparam int CoreW     = 3;
  localparam int TaskW     = 16;
  localparam int GangW     = 16;
  localparam int PrioW     = 7;
  localparam int DeadlineW = 64;
  localparam int BudgetW   = 32;
  localparam int StatusW   = 3;
  localparam int OutMaskW  = 8;
  localparam int NppW      = 8;
  localparam int CfgIdxW   = 2;

  localparam logic [NppW-1:0] NppMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_ACQUIRE    = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_NPP_LOCK   = 2'd2,
    OP_NPP_UNLOCK = 2'd3
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_BLOCK        = 3'd1,
    ST_NPP_BLOCK    = 3'd2,
    ST_NOT_REALTIME = 3'd3,
    ST_NOT_MEMBER   = 3'd4,
    ST_NOT_HELD     = 3'd5,
    ST_BUSY         = 3'd6
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_BUDGET = 2'd0,
    CFG_MAX_BUDGET     = 2'd1
  } cfg_reg_t;

  localparam logic [BudgetW-1:0] DefaultBudgetRst = '0;
  localparam logic [BudgetW-1:0] MaxBudgetRst     = '1;

endpackage

// ===== rtl/gla_if.sv =====
// Valid/ready channel interfaces of the gang lock arbiter: events, results
// and configuration writes. Depends on gla_pkg for the field widths.
`timescale 1ns / 1ps

interface gla_in_if;
  import gla_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       op;
  logic [CoreW-1:0]     core;
  logic [TaskW-1:0]     task_id;
  logic [TaskW-1:0]     prev_task_id;
  logic [GangW-1:0]     gang_id;
  logic                 is_edf;
  logic                 is_realtime;
  logic [PrioW-1:0]     priority_req;
  logic [DeadlineW-1:0] deadline;
  logic [BudgetW-1:0]   own_budget;

  modport source (
    output valid, op, core, task_id, prev_task_id, gang_id, is_edf, is_realtime,
           priority_req, deadline, own_budget,
    input  ready
  );
  modport sink (
    input  valid, op, core, task_id, prev_task_id, gang_id, is_edf, is_realtime,
           priority_req, deadline, own_budget,
    output ready
  );
endinterface

interface gla_out_if;
  import gla_pkg::*;
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [OutMaskW-1:0] resched_mask;
  logic [OutMaskW-1:0] preempt_mask;
  logic                budget_valid;
  logic [BudgetW-1:0]  budget;
  logic                lock_busy;

  modport source (
    output valid, status, resched_mask, preempt_mask, budget_valid, budget, lock_busy,
    input  ready
  );
  modport sink (
    input  valid, status, resched_mask, preempt_mask, budget_valid, budget, lock_busy,
    output ready
  );
endinterface

interface gla_cfg_if;
  import gla_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [BudgetW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gang_lock_arbiter.sv =====
// Top level of the gang lock arbiter: input register, event decode and
// state update, result register. Depends on gla_pkg, gla_if.sv, assert_macros.svh.
//
//   channel  dir  handshake      carries
//   in_ch    in   valid/ready    one scheduling event item (op, core, task, gang, ...)
//   out_ch   out  valid/ready    one result item per event (status, masks, budget)
//   cfg_ch   in   valid/ready    register index and 32-bit write data
//
// An item is accepted into the input register, and once it can move on (the
// result register is empty or drained) it is evaluated against the lock state
// and lands in the result register: one item per cycle sustained while the
// result side does not stall. The rate is set by the single compare-and-update
// pass over the per-core lock registers. The input register refills while a
// result waits, so a stalled result side holds at most two items. Reset (rst_n
// low at a clock edge) frees the lock and empties both registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gang_lock_arbiter #(
  parameter int NUM_CORES = gla_pkg::GLA_NUM_CORES
) (
  input  logic      clk,
  input  logic      rst_n,
  gla_in_if.sink    in_ch,
  gla_out_if.source out_ch,
  gla_cfg_if.sink   cfg_ch
);
  import gla_pkg::*;

  localparam int CoreIdxW = $clog2(NUM_CORES);
  // Masks are widened to at least the output width before the low bits are taken.
  localparam int ExtMaskW = (NUM_CORES > OutMaskW) ? NUM_CORES : OutMaskW;

  // Configuration registers.
  logic [BudgetW-1:0] default_budget_r;
  logic [BudgetW-1:0] max_budget_r;

  // Input register.
  logic                 in_v_r;
  op_t                  in_op_r;
  logic [CoreW-1:0]     in_core_r;
  logic [TaskW-1:0]     in_task_r;
  logic [TaskW-1:0]     in_prev_r;
  logic [GangW-1:0]     in_gang_r;
  logic                 in_edf_r;
  logic                 in_rt_r;
  logic [PrioW-1:0]     in_prio_r;
  logic [DeadlineW-1:0] in_dl_r;
  logic [BudgetW-1:0]   in_own_r;

  // Lock state.
  logic                 busy_r, busy_nxt;
  logic [GangW-1:0]     leader_gang_r, leader_gang_nxt;
  logic                 leader_edf_r, leader_edf_nxt;
  logic [PrioW-1:0]     leader_prio_r, leader_prio_nxt;
  logic [DeadlineW-1:0] leader_dl_r, leader_dl_nxt;
  logic [NUM_CORES-1:0] locked_r, locked_nxt;
  logic [NUM_CORES-1:0] blocked_r, blocked_nxt;
  logic [NppW-1:0]      npp_r, npp_nxt;
  logic                 hp_wait_r, hp_wait_nxt;
  logic [TaskW-1:0]     holder_r [NUM_CORES];

  // Result register.
  logic                out_v_r;
  status_t             out_status_r, status_nxt;
  logic [OutMaskW-1:0] out_resched_r;
  logic [OutMaskW-1:0] out_preempt_r;
  logic                out_bvalid_r, bvalid_nxt;
  logic [BudgetW-1:0]  out_budget_r, budget_nxt;
  logic                out_busy_r;

  logic                 advance;
  logic                 in_range;
  logic [CoreIdxW-1:0]  core_idx;
  logic [NUM_CORES-1:0] core_bit;
  logic                 member;
  logic                 wins;
  logic [BudgetW-1:0]   new_budget;
  logic [NUM_CORES-1:0] release_hit;
  logic [NUM_CORES-1:0] locked_rel;
  logic [NUM_CORES-1:0] resched_nxt, preempt_nxt;
  logic [ExtMaskW-1:0]  resched_ext, preempt_ext;
  logic                 holder_we;
  logic [TaskW-1:0]     holder_wdata;

  // The input register moves on whenever the result register is empty or drained.
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_budget_r <= DefaultBudgetRst;
      max_budget_r     <= MaxBudgetRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEFAULT_BUDGET: default_budget_r <= cfg_ch.data;
        CFG_MAX_BUDGET:     max_budget_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r   <= op_t'(in_ch.op);
      in_core_r <= in_ch.core;
      in_task_r <= in_ch.task_id;
      in_prev_r <= in_ch.prev_task_id;
      in_gang_r <= in_ch.gang_id;
      in_edf_r  <= in_ch.is_edf;
      in_rt_r   <= in_ch.is_realtime;
      in_prio_r <= in_ch.priority_req;
      in_dl_r   <= in_ch.deadline;
      in_own_r  <= in_ch.own_budget;
    end
  end

  // Event decode. Cores past the configured count are ignored.
  assign in_range   = (32'(in_core_r) < NUM_CORES);
  assign core_idx   = CoreIdxW'(in_core_r);
  assign core_bit   = NUM_CORES'(1) << core_idx;
  assign member     = busy_r && (in_gang_r == leader_gang_r);
  assign new_budget = (in_own_r != '0) ? in_own_r : default_budget_r;

  // A request of the leader's class wins on a strictly earlier deadline or a
  // strictly lower priority number; a deadline task always beats a fixed one.
  always_comb begin
    if (in_edf_r == leader_edf_r) begin
      wins = in_edf_r ? (in_dl_r < leader_dl_r) : (in_prio_r < leader_prio_r);
    end else begin
      wins = in_edf_r;
    end
  end

  // A release drops every locked core whose holder is the released task.
  always_comb begin
    for (int c = 0; c < NUM_CORES; c++) begin
      release_hit[c] = locked_r[c] && (holder_r[c] == in_task_r);
    end
    locked_rel = locked_r & ~release_hit;
  end

  always_comb begin
    busy_nxt        = busy_r;
    leader_gang_nxt = leader_gang_r;
    leader_edf_nxt  = leader_edf_r;
    leader_prio_nxt = leader_prio_r;
    leader_dl_nxt   = leader_dl_r;
    locked_nxt      = locked_r;
    blocked_nxt     = blocked_r;
    npp_nxt         = npp_r;
    hp_wait_nxt     = hp_wait_r;
    holder_we       = 1'b0;
    holder_wdata    = in_task_r;
    status_nxt      = ST_OK;
    resched_nxt     = '0;
    preempt_nxt     = '0;
    bvalid_nxt      = 1'b0;
    budget_nxt      = '0;

    if (in_range) begin
      case (in_op_r)
        OP_ACQUIRE: begin
          if (!busy_r) begin
            // Free lock: this task starts a new gang.
            locked_nxt      = locked_r | core_bit;
            holder_we       = 1'b1;
            busy_nxt        = 1'b1;
            leader_gang_nxt = in_gang_r;
            leader_edf_nxt  = in_edf_r;
            leader_prio_nxt = in_prio_r;
            leader_dl_nxt   = in_dl_r;
            bvalid_nxt      = 1'b1;
            budget_nxt      = new_budget;
          end else if (member) begin
            locked_nxt = locked_r | core_bit;
            holder_we  = 1'b1;
          end else if (wins && (npp_r != '0)) begin
            // The leader is inside a non-preemptive section: the core keeps
            // its previous task and waits for the section to end.
            hp_wait_nxt  = 1'b1;
            blocked_nxt  = blocked_r | core_bit;
            locked_nxt   = locked_r | core_bit;
            holder_we    = 1'b1;
            holder_wdata = in_prev_r;
            status_nxt   = ST_NPP_BLOCK;
          end else if (wins) begin
            // Preemption: the other cores of the old gang are kicked out.
            preempt_nxt     = locked_r & ~core_bit;
            locked_nxt      = core_bit;
            holder_we       = 1'b1;
            leader_gang_nxt = in_gang_r;
            leader_edf_nxt  = in_edf_r;
            leader_prio_nxt = in_prio_r;
            leader_dl_nxt   = in_dl_r;
            blocked_nxt     = blocked_r | core_bit;
            bvalid_nxt      = 1'b1;
            budget_nxt      = new_budget;
          end else begin
            blocked_nxt = blocked_r | core_bit;
            status_nxt  = ST_BLOCK;
          end
        end
        OP_RELEASE: begin
          if (busy_r) begin
            locked_nxt = locked_rel;
            // The lock is freed only when no core holds it and no
            // non-preemptive section is open.
            if ((npp_r == '0) && (locked_rel == '0)) begin
              busy_nxt        = 1'b0;
              leader_gang_nxt = '0;
              leader_edf_nxt  = 1'b0;
              leader_prio_nxt = '0;
              leader_dl_nxt   = '0;
              resched_nxt     = blocked_r & ~core_bit;
              blocked_nxt     = '0;
              bvalid_nxt      = 1'b1;
              budget_nxt      = max_budget_r;
            end
          end
        end
        default: begin
          // Non-preemptive lock and unlock.
          if (!in_rt_r) begin
            status_nxt = ST_NOT_REALTIME;
          end else if (!member) begin
            status_nxt = ST_NOT_MEMBER;
          end else if (in_op_r == OP_NPP_LOCK) begin
            if (hp_wait_r) begin
              status_nxt = ST_BUSY;
            end else if (npp_r != NppMax) begin
              npp_nxt = npp_r + NppW'(1);
            end
          end else if (npp_r == '0) begin
            status_nxt = ST_NOT_HELD;
          end else begin
            npp_nxt = npp_r - NppW'(1);
            // Leaving the last section wakes the cores that waited on it.
            if ((npp_r == NppW'(1)) && hp_wait_r) begin
              hp_wait_nxt = 1'b0;
              resched_nxt = blocked_r & ~core_bit;
              blocked_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  assign resched_ext = ExtMaskW'(resched_nxt);
  assign preempt_ext = ExtMaskW'(preempt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      leader_gang_r <= '0;
      leader_edf_r  <= 1'b0;
      leader_prio_r <= '0;
      leader_dl_r   <= '0;
      locked_r      <= '0;
      blocked_r     <= '0;
      npp_r         <= '0;
      hp_wait_r     <= 1'b0;
    end else if (advance) begin
      busy_r        <= busy_nxt;
      leader_gang_r <= leader_gang_nxt;
      leader_edf_r  <= leader_edf_nxt;
      leader_prio_r <= leader_prio_nxt;
      leader_dl_r   <= leader_dl_nxt;
      locked_r      <= locked_nxt;
      blocked_r     <= blocked_nxt;
      npp_r         <= npp_nxt;
      hp_wait_r     <= hp_wait_nxt;
    end
  end

  // Holder entries are only read for locked cores, which are always written first.
  always_ff @(posedge clk) begin
    if (advance && holder_we) begin
      holder_r[core_idx] <= holder_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r  <= status_nxt;
      out_resched_r <= resched_ext[OutMaskW-1:0];
      out_preempt_r <= preempt_ext[OutMaskW-1:0];
      out_bvalid_r  <= bvalid_nxt;
      out_budget_r  <= budget_nxt;
      out_busy_r    <= busy_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.resched_mask = out_resched_r;
  assign out_ch.preempt_mask = out_preempt_r;
  assign out_ch.budget_valid = out_bvalid_r;
  assign out_ch.budget       = out_budget_r;
  assign out_ch.lock_busy    = out_busy_r;

  // A free lock has no locked core and no open non-preemptive section.
  `ASSERT_CLK(a_free_is_clean, clk, rst_n, !busy_r |-> (locked_r == '0) && (npp_r == '0))
  // A waiting preemptor implies an open non-preemptive section.
  `ASSERT_CLK(a_hp_wait_needs_npp, clk, rst_n, hp_wait_r |-> (npp_r != '0))
  // A full pipeline with a stalled result side takes no new item.
  `ASSERT_CLK(a_stall_blocks_input, clk, rst_n, in_v_r && out_v_r && !out_ch.ready |-> !in_ch.ready)
  // An item that leaves the input register shows up as a result next cycle.
  `ASSERT_CLK(a_advance_fills_out, clk, rst_n, advance |=> out_v_r)
  // Without a new budget the budget field reads zero.
  `ASSERT_CLK(a_budget_zero, clk, rst_n, out_v_r && !out_bvalid_r |-> (out_budget_r == '0))
  // Reset empties both registers.
  `ASSERT_NORST(a_reset_empties, clk, !rst_n |=> !in_v_r && !out_v_r)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the gang lock arbiter: directed and random scheduling events,
// a cycle-free predictor of the lock state, and random idling on both channels.
// Depends on gla_pkg, the channel interfaces in gla_if.sv and the gang_lock_arbiter top level.
`timescale 1ns / 1ps

module testbench;
  import gla_pkg::*;

  typedef struct {
    op_t                  op;
    logic [CoreW-1:0]     core;
    logic [TaskW-1:0]     task_id;
    logic [TaskW-1:0]     prev_task_id;
    logic [GangW-1:0]     gang_id;
    logic                 is_edf;
    logic                 is_realtime;
    logic [PrioW-1:0]     priority_req;
    logic [DeadlineW-1:0] deadline;
    logic [BudgetW-1:0]   own_budget;
  } sched_item_t;

  typedef struct {
    status_t             status;
    logic [OutMaskW-1:0] resched_mask;
    logic [OutMaskW-1:0] preempt_mask;
    logic                budget_valid;
    logic [BudgetW-1:0]  budget;
    logic                lock_busy;
  } lock_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gla_in_if  in_if ();
  gla_out_if out_if ();
  gla_cfg_if cfg_if ();

  gang_lock_arbiter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Events waiting to be offered, and outcomes predicted for accepted events.
  sched_item_t   sched_queue[$];
  lock_outcome_t outcome_queue[$];
  sched_item_t   driven_item;
  lock_outcome_t expected_now;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;

  // Predicted lock state and register copies.
  logic                 lk_busy;
  logic [GangW-1:0]     lk_gang;
  logic                 lk_edf;
  logic [PrioW-1:0]     lk_prio;
  logic [DeadlineW-1:0] lk_deadline;
  logic [TaskW-1:0]     lk_holder[GLA_NUM_CORES];
  logic [OutMaskW-1:0]  lk_locked;
  logic [OutMaskW-1:0]  lk_blocked;
  logic [NppW-1:0]      lk_npp;
  logic                 lk_hp_waiting;
  logic [BudgetW-1:0]   reg_default_budget;
  logic [BudgetW-1:0]   reg_max_budget;

  // Applies one accepted event to the predicted lock state and returns its outcome.
  function automatic lock_outcome_t predict_outcome(sched_item_t it);
    lock_outcome_t       r;
    logic [OutMaskW-1:0] core_bit;
    logic                member;
    logic                wins;
    r.status       = ST_OK;
    r.resched_mask = '0;
    r.preempt_mask = '0;
    r.budget_valid = 1'b0;
    r.budget       = '0;
    if (int'(it.core) < GLA_NUM_CORES) begin
      core_bit = '0;
      core_bit[it.core] = 1'b1;
      member = lk_busy && (it.gang_id == lk_gang);
      case (it.op)
        OP_ACQUIRE: begin
          if (!lk_busy) begin
            lk_locked |= core_bit;
            lk_holder[it.core] = it.task_id;
            lk_busy     = 1'b1;
            lk_gang     = it.gang_id;
            lk_edf      = it.is_edf;
            lk_prio     = it.priority_req;
            lk_deadline = it.deadline;
            r.budget_valid = 1'b1;
            r.budget = (it.own_budget != '0) ? it.own_budget : reg_default_budget;
          end else if (member) begin
            lk_locked |= core_bit;
            lk_holder[it.core] = it.task_id;
          end else begin
            // Same class compares deadline or priority; a deadline task beats a
            // fixed-priority leader outright.
            if (it.is_edf == lk_edf)
              wins = it.is_edf ? (it.deadline < lk_deadline) : (it.priority_req < lk_prio);
            else
              wins = it.is_edf;
            if (wins && lk_npp != '0) begin
              // The winner waits behind the non-preemptive section; the core is
              // held on by the task that was leaving it.
              lk_hp_waiting = 1'b1;
              lk_blocked |= core_bit;
              lk_locked  |= core_bit;
              lk_holder[it.core] = it.prev_task_id;
              r.status = ST_NPP_BLOCK;
            end else if (wins) begin
              r.preempt_mask = lk_locked & ~core_bit;
              lk_locked = core_bit;
              lk_holder[it.core] = it.task_id;
              lk_gang     = it.gang_id;
              lk_edf      = it.is_edf;
              lk_prio     = it.priority_req;
              lk_deadline = it.deadline;
              lk_blocked |= core_bit;
              r.budget_valid = 1'b1;
              r.budget = (it.own_budget != '0) ? it.own_budget : reg_default_budget;
            end else begin
              lk_blocked |= core_bit;
              r.status = ST_BLOCK;
            end
          end
        end
        OP_RELEASE: begin
          if (lk_busy) begin
            for (int c = 0; c < GLA_NUM_CORES; c++)
              if (lk_locked[c] && lk_holder[c] == it.task_id)
                lk_locked[c] = 1'b0;
            // The lock is freed only when no core holds it and no
            // non-preemptive section is open.
            if (lk_npp == '0 && lk_locked == '0) begin
              lk_busy     = 1'b0;
              lk_gang     = '0;
              lk_edf      = 1'b0;
              lk_prio     = '0;
              lk_deadline = '0;
              r.resched_mask = lk_blocked & ~core_bit;
              lk_blocked = '0;
              r.budget_valid = 1'b1;
              r.budget = reg_max_budget;
            end
          end
        end
        default: begin
          if (!it.is_realtime) begin
            r.status = ST_NOT_REALTIME;
          end else if (!member) begin
            r.status = ST_NOT_MEMBER;
          end else if (it.op == OP_NPP_LOCK) begin
            if (lk_hp_waiting)
              r.status = ST_BUSY;
            else if (lk_npp != NppMax)
              lk_npp = lk_npp + NppW'(1);
          end else if (lk_npp == '0) begin
            r.status = ST_NOT_HELD;
          end else begin
            lk_npp = lk_npp - NppW'(1);
            if (lk_npp == '0 && lk_hp_waiting) begin
              lk_hp_waiting = 1'b0;
              r.resched_mask = lk_blocked & ~core_bit;
              lk_blocked = '0;
            end
          end
        end
      endcase
    end
    r.lock_busy = lk_busy;
    return r;
  endfunction

  task automatic queue_item(op_t op, logic [CoreW-1:0] core, logic [TaskW-1:0] tid,
                            logic [TaskW-1:0] prev, logic [GangW-1:0] gang, logic edf,
                            logic rt, logic [PrioW-1:0] prio, logic [DeadlineW-1:0] dl,
                            logic [BudgetW-1:0] own);
    sched_item_t it;
    it.op           = op;
    it.core         = core;
    it.task_id      = tid;
    it.prev_task_id = prev;
    it.gang_id      = gang;
    it.is_edf       = edf;
    it.is_realtime  = rt;
    it.priority_req = prio;
    it.deadline     = dl;
    it.own_budget   = own;
    sched_queue.push_back(it);
  endtask

  // Deadlines mix the extremes with small values, so that compares often decide.
  function automatic logic [DeadlineW-1:0] pick_deadline();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return DeadlineW'($urandom_range(1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PrioW-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return '0;
      1:       return PrioW'(99);
      default: return PrioW'($urandom_range(99));
    endcase
  endfunction

  function automatic logic [BudgetW-1:0] pick_own_budget();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_register(cfg_reg_t idx, logic [BudgetW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_DEFAULT_BUDGET: reg_default_budget = value;
      CFG_MAX_BUDGET:     reg_max_budget     = value;
      default: ;
    endcase
  endtask

  // Waits until every event has been accepted and every outcome checked, then lets
  // the two-stage pipeline settle.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (sched_queue.size() != 0 || in_if.valid || outcome_queue.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Event driver: predicts each accepted item, then offers the next one unless idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        outcome_queue.push_back(predict_outcome(driven_item));
      if (!in_if.valid || in_if.ready) begin
        if (sched_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_item = sched_queue.pop_front();
          in_if.valid        <= 1'b1;
          in_if.op           <= driven_item.op;
          in_if.core         <= driven_item.core;
          in_if.task_id      <= driven_item.task_id;
          in_if.prev_task_id <= driven_item.prev_task_id;
          in_if.gang_id      <= driven_item.gang_id;
          in_if.is_edf       <= driven_item.is_edf;
          in_if.is_realtime  <= driven_item.is_realtime;
          in_if.priority_req <= driven_item.priority_req;
          in_if.deadline     <= driven_item.deadline;
          in_if.own_budget   <= driven_item.own_budget;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (outcome_queue.size() == 0) begin
          $error("result item arrived with no event outstanding");
          error_count++;
        end else begin
          expected_now = outcome_queue.pop_front();
          if (out_if.status !== expected_now.status) begin
            $error("status expected %0d actual %0d", expected_now.status, out_if.status);
            error_count++;
          end
          if (out_if.resched_mask !== expected_now.resched_mask) begin
            $error("resched_mask expected %h actual %h",
                   expected_now.resched_mask, out_if.resched_mask);
            error_count++;
          end
          if (out_if.preempt_mask !== expected_now.preempt_mask) begin
            $error("preempt_mask expected %h actual %h",
                   expected_now.preempt_mask, out_if.preempt_mask);
            error_count++;
          end
          if (out_if.budget_valid !== expected_now.budget_valid) begin
            $error("budget_valid expected %b actual %b",
                   expected_now.budget_valid, out_if.budget_valid);
            error_count++;
          end
          if (out_if.budget !== expected_now.budget) begin
            $error("budget expected %h actual %h", expected_now.budget, out_if.budget);
            error_count++;
          end
          if (out_if.lock_busy !== expected_now.lock_busy) begin
            $error("lock_busy expected %b actual %b", expected_now.lock_busy, out_if.lock_busy);
            error_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    logic [GangW-1:0]     gang_pool[4];
    logic [CoreW-1:0]     cores[4];
    logic [TaskW-1:0]     tids[4];
    logic [GangW-1:0]     gang;
    logic                 edf;
    logic [PrioW-1:0]     prio;
    logic [DeadlineW-1:0] dl;
    logic [BudgetW-1:0]   own;
    logic [BudgetW-1:0]   default_setting[4];
    logic [BudgetW-1:0]   max_setting[4];
    int                   idle_setting[4];
    int                   stall_setting[4];
    int                   n;
    int                   depth;
    int                   start;

    in_if.valid        = 1'b0;
    in_if.op           = OP_ACQUIRE;
    in_if.core         = '0;
    in_if.task_id      = '0;
    in_if.prev_task_id = '0;
    in_if.gang_id      = '0;
    in_if.is_edf       = 1'b0;
    in_if.is_realtime  = 1'b0;
    in_if.priority_req = '0;
    in_if.deadline     = '0;
    in_if.own_budget   = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_DEFAULT_BUDGET;
    cfg_if.data        = '0;

    lk_busy       = 1'b0;
    lk_gang       = '0;
    lk_edf        = 1'b0;
    lk_prio       = '0;
    lk_deadline   = '0;
    lk_locked     = '0;
    lk_blocked    = '0;
    lk_npp        = '0;
    lk_hp_waiting = 1'b0;
    for (int c = 0; c < GLA_NUM_CORES; c++) lk_holder[c] = '0;
    reg_default_budget = DefaultBudgetRst;
    reg_max_budget     = MaxBudgetRst;

    // Register settings per phase, extremes included; idling and stalling vary by phase.
    default_setting = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_FFFF, $urandom};
    max_setting     = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001};
    idle_setting    = '{0, 66, 0, 30};
    stall_setting   = '{0, 0, 66, 30};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_setting[phase];
      recv_stall_pct = stall_setting[phase];
      write_register(CFG_DEFAULT_BUDGET, default_setting[phase]);
      write_register(CFG_MAX_BUDGET, max_setting[phase]);

      if (phase == 0) begin
        // Requests against a free lock: release is a no-op, npp requests are refused.
        queue_item(OP_RELEASE,    0, 5, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_NPP_LOCK,   0, 1, 0, 10, 0, 0, 0, 0, 0);
        queue_item(OP_NPP_LOCK,   0, 1, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_NPP_UNLOCK, 0, 1, 0, 10, 0, 1, 0, 0, 0);
        // Gang 10 starts with the default budget and grows; gang 20 is blocked.
        queue_item(OP_ACQUIRE,    0, 1, 0, 10, 0, 1, 50, 0, 0);
        queue_item(OP_ACQUIRE,    1, 2, 0, 10, 0, 0, 50, 0, 0);
        queue_item(OP_ACQUIRE,    2, 3, 0, 20, 0, 1, 50, 0, 0);
        queue_item(OP_ACQUIRE,    2, 3, 0, 20, 0, 1, 99, 0, 0);
        queue_item(OP_NPP_UNLOCK, 0, 1, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_NPP_LOCK,   0, 1, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_NPP_LOCK,   1, 2, 0, 30, 0, 1, 0, 0, 0);
        // A deadline task would preempt but waits behind the open npp section.
        queue_item(OP_ACQUIRE,    3, 4, 44, 20, 1, 1, 0, 100, 0);
        queue_item(OP_NPP_LOCK,   0, 1, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_NPP_UNLOCK, 0, 1, 0, 10, 0, 1, 0, 0, 0);
        queue_item(OP_RELEASE,    0, 1, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_RELEASE,    3, 44, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_RELEASE,    1, 2, 0, 0, 0, 0, 0, 0, 0);
        // Preemption chain: lower priority number, deadline over fixed priority,
        // equal deadline, fixed priority against a deadline leader, earlier deadline.
        queue_item(OP_ACQUIRE,    4, 6, 0, 40, 0, 1, 99, 0, '1);
        queue_item(OP_ACQUIRE,    5, 7, 0, 50, 0, 1, 0, 0, 1);
        queue_item(OP_ACQUIRE,    6, 8, 0, 60, 1, 1, 0, '1, 0);
        queue_item(OP_ACQUIRE,    7, 9, 0, 70, 1, 1, 0, '1, 0);
        queue_item(OP_ACQUIRE,    0, 10, 0, 80, 0, 1, 0, 0, 0);
        queue_item(OP_ACQUIRE,    1, 11, 0, 90, 1, 1, 0, 0, 0);
        // Nesting saturates at its top count.
        for (int i = 0; i < 256; i++)
          queue_item(OP_NPP_LOCK, 1, 11, 0, 90, 1, 1, 0, 0, 0);
        // The release is deferred; the lock stays busy with no core held, and both a
        // rival and a member are judged against the kept leader.
        queue_item(OP_RELEASE,    1, 11, 0, 0, 0, 0, 0, 0, 0);
        queue_item(OP_ACQUIRE,    2, 12, 0, 100, 1, 1, 0, 5, 0);
        queue_item(OP_ACQUIRE,    3, 13, 0, 90, 1, 1, 0, 0, 0);
        for (int i = 0; i < 255; i++)
          queue_item(OP_NPP_UNLOCK, 3, 13, 0, 90, 1, 1, 0, 0, 0);
        queue_item(OP_RELEASE,    3, 13, 0, 0, 0, 0, 0, 0, 0);
      end

      // Random part: mostly gang runs (acquire on a few cores, an optional npp
      // section with a rival arriving inside it, releases), the rest noise.
      for (int k = 0; k < 4; k++) gang_pool[k] = GangW'($urandom);
      start = sched_queue.size();
      while (sched_queue.size() - start < 320) begin
        if ($urandom_range(99) < 15) begin
          queue_item(op_t'($urandom_range(3)), CoreW'($urandom_range(7)), TaskW'($urandom),
                     TaskW'($urandom), ($urandom_range(1) != 0) ? gang_pool[$urandom_range(3)]
                                                                : GangW'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)), PrioW'($urandom_range(99)),
                     {$urandom, $urandom}, $urandom);
        end else begin
          gang = gang_pool[$urandom_range(3)];
          edf  = 1'($urandom_range(1));
          prio = pick_priority();
          dl   = pick_deadline();
          own  = pick_own_budget();
          n    = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            cores[i] = CoreW'($urandom_range(7));
            tids[i]  = TaskW'($urandom_range(1, 12));
            queue_item(OP_ACQUIRE, cores[i], tids[i], TaskW'($urandom_range(1, 12)), gang,
                       edf, 1'($urandom_range(1)), prio, dl, own);
          end
          depth = $urandom_range(2);
          for (int j = 0; j < depth; j++)
            queue_item(OP_NPP_LOCK, cores[0], tids[0], 0, gang, edf,
                       $urandom_range(9) != 0, prio, dl, own);
          if ($urandom_range(99) < 40)
            queue_item(OP_ACQUIRE, CoreW'($urandom_range(7)), TaskW'($urandom_range(1, 12)),
                       TaskW'($urandom_range(1, 12)), gang_pool[$urandom_range(3)],
                       1'($urandom_range(1)), 1'b1, pick_priority(), pick_deadline(),
                       pick_own_budget());
          for (int j = 0; j < depth; j++)
            queue_item(OP_NPP_UNLOCK, cores[0], tids[0], 0, gang, edf,
                       $urandom_range(9) != 0, prio, dl, own);
          for (int i = 0; i < n; i++)
            if ($urandom_range(9) != 0)
              queue_item(OP_RELEASE, CoreW'($urandom_range(7)), tids[i], 0, gang, edf, 1'b1,
                         prio, dl, own);
          // Frees cores held on by a leaving task after an npp block.
          if ($urandom_range(99) < 20)
            queue_item(OP_RELEASE, CoreW'($urandom_range(7)), TaskW'($urandom_range(1, 12)),
                       0, gang, edf, 1'b1, prio, dl, own);
        end
      end

      wait_for_drain();
    end

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
